// ----- hdl/rgbp_pkg.sv -----
`default_nettype none
package rgbp_pkg;
	localparam int unsigned SAMPLES   = 8;
	localparam int unsigned SAMPLE_W  = 8;
	localparam int unsigned MODE_W    = 3;
	localparam int unsigned SLOTS     = 8;
	localparam int unsigned WORD_W    = SLOTS * MODE_W;
	localparam int unsigned DATA_W    = SAMPLES * SAMPLE_W;
	localparam int unsigned BYTES_W   = 4;
	localparam int unsigned SLOT_W    = $clog2(SLOTS);
	localparam int unsigned OUT_W     = DATA_W + BYTES_W + MODE_W + WORD_W;
	localparam int unsigned OUT_PAD_W = ((OUT_W + 7) / 8) * 8;
	localparam int unsigned MIN_WIDTH = 2;
	localparam int unsigned MAX_WIDTH = SAMPLE_W;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef sample_t [SAMPLES-1:0] group_t;

	typedef struct packed {
		logic [DATA_W-1:0]  packed_data;
		logic [BYTES_W-1:0] packed_bytes;
		logic [MODE_W-1:0]  group_mode;
	} grp_result_t;
endpackage
`default_nettype wire

// ----- hdl/rgbp_group_pack.sv -----
`default_nettype none
module rgbp_group_pack
	import rgbp_pkg::*;
(
	input  wire group_t  samples,
	output grp_result_t result
);
	sample_t           or_fold;
	logic              any_raw;
	logic [2:0]        top;
	logic [BYTES_W-1:0] width;
	logic [DATA_W-1:0] cand [MIN_WIDTH:MAX_WIDTH];

	always_comb begin
		or_fold = 8'h01;
		any_raw = 1'b0;
		for (int i = 0; i < SAMPLES; i++) begin
			or_fold = or_fold | (samples[i][SAMPLE_W-1] ? ~samples[i] : samples[i]);
			any_raw = any_raw | (|samples[i]);
		end
		top = 3'd0;
		for (int k = 1; k < SAMPLE_W - 1; k++) begin
			if (or_fold[k]) begin
				top = 3'(k);
			end
		end
		width = BYTES_W'(top) + BYTES_W'(MIN_WIDTH);
	end

	for (genvar w = MIN_WIDTH; w <= MAX_WIDTH; w++) begin : g_width
		always_comb begin
			logic [DATA_W-1:0] acc;
			logic [w-1:0]      bias;
			acc  = '0;
			bias = '0;
			bias[w-1] = 1'b1;
			for (int i = 0; i < SAMPLES; i++) begin
				acc[i*w +: w] = samples[i][w-1:0] ^ bias;
			end
			cand[w] = acc;
		end
	end

	always_comb begin
		result.packed_data  = '0;
		result.packed_bytes = '0;
		result.group_mode   = '0;
		if (any_raw) begin
			result.packed_bytes = width;
			result.group_mode   = MODE_W'(top) + MODE_W'(1);
			case (width)
				4'd2:    result.packed_data = cand[2];
				4'd3:    result.packed_data = cand[3];
				4'd4:    result.packed_data = cand[4];
				4'd5:    result.packed_data = cand[5];
				4'd6:    result.packed_data = cand[6];
				4'd7:    result.packed_data = cand[7];
				default: result.packed_data = cand[8];
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hdl/residual_group_bit_packer.sv -----
// An input group is held in the input register, then moves to the output register, where its result is
// offered; it waits in the input register while the output register holds a result not yet taken.
// Throughput: one group per cycle while results are taken; an input register and an output register
// let a new group enter while a finished result waits to be taken.
// The mode word accumulator updates as each group moves to the output register.
// Reset (arst_n low, asynchronous) empties both stages and clears accumulator and slot.
`default_nettype none
module residual_group_bit_packer
	import rgbp_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	// residual_a[7:0], residual_b .. residual_h[63:56]
	input  wire  [DATA_W-1:0]   s_tdata,
	input  wire                 s_tlast,
	output logic                m_tvalid,
	input  wire                 m_tready,
	// packed_data[63:0], packed_bytes[67:64], group_mode[70:68], mode_word[94:71], zero
	output logic [OUT_PAD_W-1:0] m_tdata,
	// mode_word_valid
	output logic                m_tuser
);
	logic              valid_s1;
	group_t            group_s1;
	logic              eop_s1;
	logic              valid_s2;
	grp_result_t       result_s2;
	logic [WORD_W-1:0] word_s2;
	logic              word_valid_s2;
	logic [WORD_W-1:0] acc_q;
	logic [SLOT_W-1:0] slot_q;

	grp_result_t       result;
	logic              advance;
	logic [WORD_W-1:0] acc_merged;
	logic              flush;

	rgbp_group_pack u_pack (
		.samples (group_s1),
		.result  (result)
	);

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign flush    = (slot_q == LAST_SLOT) || eop_s1;

	always_comb begin
		acc_merged = acc_q;
		acc_merged[slot_q*MODE_W +: MODE_W] = result.group_mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			group_s1 <= s_tdata;
			eop_s1   <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			acc_q    <= '0;
			slot_q   <= '0;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
				if (flush) begin
					acc_q  <= '0;
					slot_q <= '0;
				end else begin
					acc_q  <= acc_merged;
					slot_q <= slot_q + SLOT_W'(1);
				end
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2     <= result;
			word_s2       <= flush ? acc_merged : '0;
			word_valid_s2 <= flush;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = word_valid_s2;
	assign m_tdata  = OUT_PAD_W'({word_s2, result_s2.group_mode, result_s2.packed_bytes,
		result_s2.packed_data});

	a_slot_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		advance && flush |=> slot_q == '0 && acc_q == '0)
		else $error("slot not cleared after mode word completed");

	a_mode_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((result_s2.packed_bytes == '0 && result_s2.group_mode == '0) ||
		(BYTES_W'(result_s2.group_mode) + BYTES_W'(1) == result_s2.packed_bytes)))
		else $error("group mode disagrees with packed width");

	a_word_gated: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> word_s2 == '0)
		else $error("mode word present without valid flag");

	a_stage_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty input stage");
endmodule
`default_nettype wire
